FILE: hw/rtl/scs_pkg.sv
`timescale 1ns / 1ps
// Package for the SQL comment stripper: transaction types, the per-byte step
// record and the character constants. It has no dependencies.
package scs_pkg;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;

    localparam int unsigned QueueDepth = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_text;
        logic       run_last;
    } out_item_t;

    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } step_t;

endpackage

FILE: hw/rtl/sql_comment_stripper.sv
`timescale 1ns / 1ps
// Top level of the SQL comment stripper: input register, scanner and result
// queue. Depends on scs_pkg, scs_scanner and scs_result_fifo.
//
// The block takes one text byte per cycle while item_stall is low. Each byte
// sits in an input register, the scanner turns it combinationally into zero,
// one or two result transactions, and these enter a four-entry result queue
// that delivers one transaction per cycle while result_stall is low. The first
// result of a byte is offered once the byte has passed the input register and
// been written into the queue, which waits for room. A byte that yields two
// results (a held '-' or '/' flushed ahead of the next byte) writes both at
// once, so a run of them is held back by the one-per-cycle queue read port.
// Input stall rises only when the queue holds more than two transactions.
module sql_comment_stripper
(
    input  logic               clk,
    input  logic               rst_n,
    input  scs_pkg::in_item_t  item,
    input  logic               item_valid,
    output logic               item_stall,
    output scs_pkg::out_item_t result,
    output logic               result_valid,
    input  logic               result_stall
);

    scs_pkg::in_item_t item_reg;
    logic              loaded_reg;
    logic              has_room;
    logic              advance;
    scs_pkg::step_t    step;

    assign advance    = loaded_reg && has_room;
    assign item_stall = loaded_reg && !has_room;

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            loaded_reg <= item_valid;
        end
    end

    scs_scanner u_scanner
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .step    (step)
    );

    scs_result_fifo u_fifo
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (advance),
        .step         (step),
        .has_room     (has_room),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

FILE: hw/rtl/scs_scanner.sv
`timescale 1ns / 1ps
// Scanner state and the combinational step that turns one text byte into up
// to two result transactions. Depends on scs_pkg.
module scs_scanner
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  scs_pkg::in_item_t item,
    output scs_pkg::step_t   step
);

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_LITERAL = 3'd1,
        MODE_LINE    = 3'd2,
        MODE_BLOCK   = 3'd3,
        MODE_STAR    = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        HELD_NONE  = 2'd0,
        HELD_MINUS = 2'd1,
        HELD_SLASH = 2'd2
    } held_t;

    mode_t      mode_reg, mode_next;
    held_t      held_reg, held_next;
    logic       dquote_reg, dquote_next;
    logic [1:0] n_emit;
    logic [7:0] byte0, byte1;
    logic [7:0] c;
    logic [7:0] close_quote;
    logic       last;

    assign c           = item.in_byte;
    assign last        = item.text_end;
    assign close_quote = dquote_reg ? scs_pkg::CH_DQUOTE : scs_pkg::CH_SQUOTE;

    always_comb
    begin
        mode_next   = mode_reg;
        held_next   = held_reg;
        dquote_next = dquote_reg;
        n_emit      = 2'd0;
        byte0       = 8'd0;
        byte1       = 8'd0;
        case (mode_reg)
            MODE_LITERAL:
            begin
                byte0  = c;
                n_emit = 2'd1;
                if (c == close_quote)
                begin
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_LINE:
            begin
                if (c == scs_pkg::CH_NL)
                begin
                    byte0     = c;
                    n_emit    = 2'd1;
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_BLOCK:
            begin
                if (c == scs_pkg::CH_STAR)
                begin
                    mode_next = MODE_STAR;
                end
            end
            MODE_STAR:
            begin
                if (c == scs_pkg::CH_SLASH)
                begin
                    mode_next = MODE_NORMAL;
                end
                else if (c != scs_pkg::CH_STAR)
                begin
                    mode_next = MODE_BLOCK;
                end
            end
            default:
            begin
                mode_next = MODE_NORMAL;
                held_next = HELD_NONE;
                if (held_reg == HELD_MINUS && c == scs_pkg::CH_MINUS)
                begin
                    mode_next = MODE_LINE;
                end
                else if (held_reg == HELD_SLASH && c == scs_pkg::CH_STAR)
                begin
                    mode_next = MODE_BLOCK;
                end
                else
                begin
                    if (held_reg == HELD_MINUS)
                    begin
                        byte0  = scs_pkg::CH_MINUS;
                        n_emit = 2'd1;
                    end
                    else if (held_reg == HELD_SLASH)
                    begin
                        byte0  = scs_pkg::CH_SLASH;
                        n_emit = 2'd1;
                    end
                    if (c == scs_pkg::CH_MINUS)
                    begin
                        held_next = HELD_MINUS;
                    end
                    else if (c == scs_pkg::CH_SLASH)
                    begin
                        held_next = HELD_SLASH;
                    end
                    else
                    begin
                        if (c == scs_pkg::CH_SQUOTE || c == scs_pkg::CH_DQUOTE)
                        begin
                            mode_next   = MODE_LITERAL;
                            dquote_next = (c == scs_pkg::CH_DQUOTE);
                        end
                        if (n_emit == 2'd0)
                        begin
                            byte0 = c;
                        end
                        else
                        begin
                            byte1 = c;
                        end
                        n_emit = n_emit + 2'd1;
                    end
                end
            end
        endcase

        if (last)
        begin
            if (held_next == HELD_MINUS || held_next == HELD_SLASH)
            begin
                if (n_emit == 2'd0)
                begin
                    byte0 = (held_next == HELD_MINUS) ? scs_pkg::CH_MINUS
                                                      : scs_pkg::CH_SLASH;
                end
                else
                begin
                    byte1 = (held_next == HELD_MINUS) ? scs_pkg::CH_MINUS
                                                      : scs_pkg::CH_SLASH;
                end
                n_emit = n_emit + 2'd1;
            end
            mode_next   = MODE_NORMAL;
            held_next   = HELD_NONE;
            dquote_next = 1'b0;
        end
    end

    always_comb
    begin
        step.first.out_byte    = byte0;
        step.first.byte_valid  = 1'b1;
        step.first.end_of_text = last && (n_emit == 2'd1);
        step.first.run_last    = (n_emit == 2'd1);
        step.second.out_byte    = byte1;
        step.second.byte_valid  = 1'b1;
        step.second.end_of_text = last;
        step.second.run_last    = 1'b1;
        step.count = n_emit;
        if (last && n_emit == 2'd0)
        begin
            step.count             = 2'd1;
            step.first.out_byte    = 8'd0;
            step.first.byte_valid  = 1'b0;
            step.first.end_of_text = 1'b1;
            step.first.run_last    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NORMAL;
            held_reg   <= HELD_NONE;
            dquote_reg <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg   <= mode_next;
            held_reg   <= held_next;
            dquote_reg <= dquote_next;
        end
    end

endmodule

FILE: hw/rtl/scs_result_fifo.sv
`timescale 1ns / 1ps
// Small result queue that takes one or two transactions per cycle and hands
// out one per cycle while result_stall is low. Depends on scs_pkg.
module scs_result_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  scs_pkg::step_t     step,
    output logic               has_room,
    output scs_pkg::out_item_t result,
    output logic               result_valid,
    input  logic               result_stall
);

    localparam int unsigned PtrW = $clog2(scs_pkg::QueueDepth);
    localparam int unsigned CntW = $clog2(scs_pkg::QueueDepth + 1);

    scs_pkg::out_item_t mem [scs_pkg::QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [1:0]      push_cnt;
    logic            pop;

    assign pop          = result_valid && !result_stall;
    assign push_cnt     = push ? step.count : 2'd0;
    assign result_valid = (count_reg != '0);
    assign result       = mem[rd_ptr_reg];
    assign has_room     = (count_reg <= CntW'(scs_pkg::QueueDepth - 2));
    assign wr_ptr_next  = wr_ptr_reg + PtrW'(push_cnt);
    assign rd_ptr_next  = rd_ptr_reg + PtrW'(pop);
    assign count_next   = count_reg + CntW'(push_cnt) - CntW'(pop);

    always_ff @(posedge clk)
    begin
        if (push && step.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= step.first;
        end
        if (push && step.count == 2'd2)
        begin
            mem[wr_ptr_reg + PtrW'(1)] <= step.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hw/rtl/scs_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the SQL comment stripper, bound to the top level.
// Depends on scs_pkg and sql_comment_stripper.
module scs_checker
(
    input logic               clk,
    input logic               rst_n,
    input scs_pkg::in_item_t  item,
    input logic               item_valid,
    input logic               item_stall,
    input scs_pkg::out_item_t result,
    input logic               result_valid,
    input logic               result_stall
);

    a_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("Input transaction changed while stalled.");

    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.end_of_text |-> result.run_last)
        else $error("End of text transaction without run_last.");

    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.byte_valid |->
            result.end_of_text && result.out_byte == 8'd0)
        else $error("Empty marker transaction is malformed.");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("Result valid dropped while stalled.");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("Result payload changed while stalled.");

endmodule

bind sql_comment_stripper scs_checker u_scs_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item         (item),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
);

FILE: tb/sql_comment_stripper_tb.sv
`timescale 1ns / 1ps
// Testbench for sql_comment_stripper: a directed table and a random byte stream
// checked against a behavioral predictor, with bursty input and a stalling sink.
// Depends on scs_pkg and the sql_comment_stripper RTL.
module sql_comment_stripper_tb;

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_LITERAL,
        MODE_LINE,
        MODE_BLOCK,
        MODE_STAR
    } scan_mode_t;

    typedef enum logic [1:0] {
        HELD_NONE,
        HELD_MINUS,
        HELD_SLASH
    } held_t;

    typedef scs_pkg::out_item_t result_q_t [$];

    typedef struct packed {
        scs_pkg::in_item_t  stim;
        logic               typed;
        logic [1:0]         n;
        scs_pkg::out_item_t r0;
        scs_pkg::out_item_t r1;
    } dir_row_t;

    localparam int                 NUM_DIR      = 27;
    localparam int                 NUM_RANDOM   = 1900;
    localparam int                 HOLD_AT      = 600;
    localparam int                 HOLD_CYCLES  = 300;
    localparam int                 DRAIN_CYCLES = 20;
    localparam int                 CYCLE_LIMIT  = 400000;
    localparam scs_pkg::out_item_t NO_RESULT    = '0;

    logic               clk;
    logic               rst_n;
    scs_pkg::in_item_t  item;
    logic               item_valid;
    logic               item_stall;
    scs_pkg::out_item_t result;
    logic               result_valid;
    logic               result_stall;

    scan_mode_t scan_mode_q = MODE_NORMAL;
    logic       quote_dq_q  = 1'b0;
    held_t      held_q      = HELD_NONE;
    logic [7:0] step_bytes [$];

    scs_pkg::out_item_t expected_results [$];
    scs_pkg::out_item_t want;
    int                 fail_count = 0;
    int                 cycle_count = 0;
    int                 burst_left = 0;
    bit                 hold_req = 1'b0;

    sql_comment_stripper u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic void queue_byte(input logic [7:0] b);
        step_bytes.insert(step_bytes.size(), b);
    endfunction

    function automatic void expect_result(input scs_pkg::out_item_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void plain_byte(input logic [7:0] c);
        if (c == scs_pkg::CH_SQUOTE || c == scs_pkg::CH_DQUOTE)
        begin
            queue_byte(c);
            scan_mode_q = MODE_LITERAL;
            quote_dq_q  = (c == scs_pkg::CH_DQUOTE);
        end
        else if (c == scs_pkg::CH_MINUS)
            held_q = HELD_MINUS;
        else if (c == scs_pkg::CH_SLASH)
            held_q = HELD_SLASH;
        else
            queue_byte(c);
    endfunction

    function automatic result_q_t strip_byte(input scs_pkg::in_item_t it);
        result_q_t          res;
        scs_pkg::out_item_t r;
        logic [7:0]         c;
        c = it.in_byte;
        step_bytes.delete();
        case (scan_mode_q)
            MODE_LITERAL:
            begin
                queue_byte(c);
                if (c == (quote_dq_q ? scs_pkg::CH_DQUOTE : scs_pkg::CH_SQUOTE))
                    scan_mode_q = MODE_NORMAL;
            end
            MODE_LINE:
            begin
                if (c == scs_pkg::CH_NL)
                begin
                    queue_byte(c);
                    scan_mode_q = MODE_NORMAL;
                end
            end
            MODE_BLOCK:
            begin
                if (c == scs_pkg::CH_STAR)
                    scan_mode_q = MODE_STAR;
            end
            MODE_STAR:
            begin
                if (c == scs_pkg::CH_SLASH)
                    scan_mode_q = MODE_NORMAL;
                else if (c != scs_pkg::CH_STAR)
                    scan_mode_q = MODE_BLOCK;
            end
            default:
            begin
                scan_mode_q = MODE_NORMAL;
                if (held_q == HELD_MINUS)
                begin
                    held_q = HELD_NONE;
                    if (c == scs_pkg::CH_MINUS)
                        scan_mode_q = MODE_LINE;
                    else
                    begin
                        queue_byte(scs_pkg::CH_MINUS);
                        plain_byte(c);
                    end
                end
                else if (held_q == HELD_SLASH)
                begin
                    held_q = HELD_NONE;
                    if (c == scs_pkg::CH_STAR)
                        scan_mode_q = MODE_BLOCK;
                    else
                    begin
                        queue_byte(scs_pkg::CH_SLASH);
                        plain_byte(c);
                    end
                end
                else
                begin
                    held_q = HELD_NONE;
                    plain_byte(c);
                end
            end
        endcase
        if (it.text_end)
        begin
            if (held_q == HELD_MINUS)
                queue_byte(scs_pkg::CH_MINUS);
            else if (held_q == HELD_SLASH)
                queue_byte(scs_pkg::CH_SLASH);
            scan_mode_q = MODE_NORMAL;
            quote_dq_q  = 1'b0;
            held_q      = HELD_NONE;
            if (step_bytes.size() == 0)
            begin
                r = '{8'h00, 1'b0, 1'b1, 1'b1};
                res.insert(res.size(), r);
                return res;
            end
        end
        foreach (step_bytes[k])
        begin
            r.out_byte    = step_bytes[k];
            r.byte_valid  = 1'b1;
            r.run_last    = (k == step_bytes.size() - 1);
            r.end_of_text = r.run_last && it.text_end;
            res.insert(res.size(), r);
        end
        return res;
    endfunction

    task automatic offer(input scs_pkg::in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                item_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        @(negedge clk);
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    initial
    begin : stimulus
        dir_row_t          dir_rows [NUM_DIR];
        result_q_t         got;
        scs_pkg::in_item_t stim;
        int                pick;

        dir_rows[0]  = '{'{8'h53, 1'b0}, 1'b1, 2'd1, '{8'h53, 1'b1, 1'b0, 1'b1}, NO_RESULT};
        dir_rows[1]  = '{'{8'h00, 1'b0}, 1'b1, 2'd1, '{8'h00, 1'b1, 1'b0, 1'b1}, NO_RESULT};
        dir_rows[2]  = '{'{8'hFF, 1'b0}, 1'b1, 2'd1, '{8'hFF, 1'b1, 1'b0, 1'b1}, NO_RESULT};
        dir_rows[3]  = '{'{scs_pkg::CH_MINUS, 1'b0}, 1'b1, 2'd0, NO_RESULT, NO_RESULT};
        dir_rows[4]  = '{'{8'h61, 1'b0}, 1'b1, 2'd2,
                         '{scs_pkg::CH_MINUS, 1'b1, 1'b0, 1'b0},
                         '{8'h61, 1'b1, 1'b0, 1'b1}};
        dir_rows[5]  = '{'{scs_pkg::CH_MINUS, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        dir_rows[6]  = '{'{scs_pkg::CH_MINUS, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        dir_rows[7]  = '{'{8'h78, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        dir_rows[8]  = '{'{scs_pkg::CH_NL, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        dir_rows[9]  = '{'{scs_pkg::CH_SLASH, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        dir_rows[10] = '{'{scs_pkg::CH_STAR, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        dir_rows[11] = '{'{scs_pkg::CH_SLASH, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        dir_rows[12] = '{'{scs_pkg::CH_STAR, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        dir_rows[13] = '{'{scs_pkg::CH_STAR, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        dir_rows[14] = '{'{scs_pkg::CH_SLASH, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        dir_rows[15] = '{'{scs_pkg::CH_SQUOTE, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        dir_rows[16] = '{'{scs_pkg::CH_SQUOTE, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        dir_rows[17] = '{'{scs_pkg::CH_SQUOTE, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        dir_rows[18] = '{'{scs_pkg::CH_DQUOTE, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        dir_rows[19] = '{'{scs_pkg::CH_SQUOTE, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        dir_rows[20] = '{'{scs_pkg::CH_SLASH, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        dir_rows[21] = '{'{scs_pkg::CH_SLASH, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        dir_rows[22] = '{'{scs_pkg::CH_MINUS, 1'b1}, 1'b1, 2'd2,
                         '{scs_pkg::CH_SLASH, 1'b1, 1'b0, 1'b0},
                         '{scs_pkg::CH_MINUS, 1'b1, 1'b1, 1'b1}};
        dir_rows[23] = '{'{scs_pkg::CH_MINUS, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        dir_rows[24] = '{'{scs_pkg::CH_MINUS, 1'b1}, 1'b1, 2'd1,
                         '{8'h00, 1'b0, 1'b1, 1'b1}, NO_RESULT};
        dir_rows[25] = '{'{scs_pkg::CH_DQUOTE, 1'b0}, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        dir_rows[26] = '{'{8'h71, 1'b1}, 1'b1, 2'd1, '{8'h71, 1'b1, 1'b1, 1'b1}, NO_RESULT};

        rst_n      = 1'b0;
        item       = '0;
        item_valid = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            offer(dir_rows[i].stim);
            got = strip_byte(dir_rows[i].stim);
            if (dir_rows[i].typed)
            begin
                if (dir_rows[i].n > 0)
                    expect_result(dir_rows[i].r0);
                if (dir_rows[i].n > 1)
                    expect_result(dir_rows[i].r1);
            end
            else
                foreach (got[k]) expect_result(got[k]);
        end

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            pick = $urandom_range(0, 15);
            case (pick)
                0:       stim.in_byte = scs_pkg::CH_SQUOTE;
                1:       stim.in_byte = scs_pkg::CH_DQUOTE;
                2, 3:    stim.in_byte = scs_pkg::CH_MINUS;
                4, 5:    stim.in_byte = scs_pkg::CH_SLASH;
                6, 7:    stim.in_byte = scs_pkg::CH_STAR;
                8:       stim.in_byte = scs_pkg::CH_NL;
                default: stim.in_byte = 8'($urandom_range(0, 255));
            endcase
            stim.text_end = ($urandom_range(0, 31) == 0);
            if (n == HOLD_AT)
                hold_req = 1'b1;
            offer(stim);
            got = strip_byte(stim);
            foreach (got[k]) expect_result(got[k]);
        end

        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("sql_comment_stripper verification clean");
        else
            $display("sql_comment_stripper verification failed");
        $finish;
    end

    initial
    begin : sink_stall
        int kind;
        int stretch;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                @(negedge clk);
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            kind    = $urandom_range(0, 2);
            stretch = $urandom_range(8, 60);
            for (int i = 0; i < stretch; i++)
            begin
                @(negedge clk);
                case (kind)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 2) == 0);
                    default: result_stall <= i[1];
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transaction %p", result);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %h, actual %h", want.out_byte, result.out_byte);
                    fail_count++;
                end
                if (result.byte_valid !== want.byte_valid)
                begin
                    $error("byte_valid: expected %b, actual %b",
                           want.byte_valid, result.byte_valid);
                    fail_count++;
                end
                if (result.end_of_text !== want.end_of_text)
                begin
                    $error("end_of_text: expected %b, actual %b",
                           want.end_of_text, result.end_of_text);
                    fail_count++;
                end
                if (result.run_last !== want.run_last)
                begin
                    $error("run_last: expected %b, actual %b", want.run_last, result.run_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sql_comment_stripper verification failed");
            $finish;
        end
    end

endmodule

FILE: sql_comment_stripper.f
hw/rtl/scs_pkg.sv
hw/rtl/scs_scanner.sv
hw/rtl/scs_result_fifo.sv
hw/rtl/sql_comment_stripper.sv
hw/rtl/scs_checker.sv
tb/sql_comment_stripper_tb.sv
